// ----- sv/proximity_gesture_recognizer_macros.svh -----
// assertion macros for the proximity gesture recogniser
// used by the top level; no other dependencies
`ifndef PROXIMITY_GESTURE_RECOGNIZER_MACROS_SVH
`define PROXIMITY_GESTURE_RECOGNIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define PGR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("pgr assertion failed");

// next-cycle implication, disabled during reset
`define PGR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("pgr assertion failed");

`else

`define PGR_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define PGR_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- sv/pgr_pkg.sv -----
// types and constants for the proximity gesture recogniser
// no dependencies; used by the interfaces and every module
package pgr_pkg;

    localparam int DIST_W      = 16;
    localparam int TIME_W      = 32;
    localparam int CODE_W      = 3;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_APPROACH  = 3'd1,
        ST_HOLD      = 3'd2,
        ST_RETRACT   = 3'd3,
        ST_APPROACH2 = 3'd4,
        ST_VOLUME    = 3'd5,
        ST_COOLDOWN  = 3'd6
    } state_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_SWIPE      = 3'd0,
        CODE_SHORT_HOLD = 3'd1,
        CODE_LONG_HOLD  = 3'd2,
        CODE_VOL_NEAR   = 3'd3,
        CODE_VOL_FAR    = 3'd4
    } gesture_code_t;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_DISTANCE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR_DISTANCE   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_DISTANCE  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MIN_TIME  = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_LONG_TIME = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWIPE_MAX_TIME = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_MAX_TIME  = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN_TIME  = 8'd7;

    // fixed timing and distance limits
    localparam logic [TIME_W-1:0] DOUBLE_GAP_MS     = 32'd700;
    localparam logic [TIME_W-1:0] VOLUME_TIMEOUT_MS = 32'd4000;
    localparam logic [TIME_W-1:0] VOLUME_STEP_MS    = 32'd150;
    localparam logic [DIST_W-1:0] VOLUME_PRESENT_MM = 16'd400;
    localparam logic [DIST_W-1:0] VOLUME_NEAR_MM    = 16'd200;
    localparam logic [DIST_W-1:0] VOLUME_FAR_LO_MM  = 16'd250;
    localparam logic [DIST_W-1:0] VOLUME_FAR_HI_MM  = 16'd350;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] near_distance;
        logic [CFG_DATA_W-1:0] far_distance;
        logic [CFG_DATA_W-1:0] hold_distance;
        logic [CFG_DATA_W-1:0] hold_min_time;
        logic [CFG_DATA_W-1:0] hold_long_time;
        logic [CFG_DATA_W-1:0] swipe_max_time;
        logic [CFG_DATA_W-1:0] wave_max_time;
        logic [CFG_DATA_W-1:0] cooldown_time;
    } cfg_t;

    typedef struct packed {
        logic          emit;
        gesture_code_t code;
    } step_t;

endpackage

// ----- sv/pgr_if.sv -----
// handshake interfaces for samples, gestures and register writes
// depends on pgr_pkg
interface pgr_sample_if;
    import pgr_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] sample_distance;
    logic [TIME_W-1:0] sample_time;

    modport source (output valid, output sample_distance, output sample_time, input ready);
    modport sink (input valid, input sample_distance, input sample_time, output ready);
endinterface

interface pgr_gesture_if;
    import pgr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] gesture_code;

    modport source (output valid, output gesture_code, input ready);
    modport sink (input valid, input gesture_code, output ready);
endinterface

interface pgr_cfg_if;
    import pgr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/pgr_cfg_regs.sv -----
// configuration register file of the gesture recogniser
// depends on pgr_pkg
module pgr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [pgr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [pgr_pkg::CFG_DATA_W-1:0]  wr_data,
    output pgr_pkg::cfg_t                   cfg
);
    import pgr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_NEAR_DISTANCE:  cfg_next.near_distance  = wr_data;
                CFG_FAR_DISTANCE:   cfg_next.far_distance   = wr_data;
                CFG_HOLD_DISTANCE:  cfg_next.hold_distance  = wr_data;
                CFG_HOLD_MIN_TIME:  cfg_next.hold_min_time  = wr_data;
                CFG_HOLD_LONG_TIME: cfg_next.hold_long_time = wr_data;
                CFG_SWIPE_MAX_TIME: cfg_next.swipe_max_time = wr_data;
                CFG_WAVE_MAX_TIME:  cfg_next.wave_max_time  = wr_data;
                CFG_COOLDOWN_TIME:  cfg_next.cooldown_time  = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_distance  <= 16'd150;
            cfg_reg.far_distance   <= 16'd350;
            cfg_reg.hold_distance  <= 16'd200;
            cfg_reg.hold_min_time  <= 16'd800;
            cfg_reg.hold_long_time <= 16'd2000;
            cfg_reg.swipe_max_time <= 16'd300;
            cfg_reg.wave_max_time  <= 16'd600;
            cfg_reg.cooldown_time  <= 16'd1200;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/pgr_median3.sv -----
// median of three distances
// depends on pgr_pkg
module pgr_median3 (
    input  logic [pgr_pkg::DIST_W-1:0] a,
    input  logic [pgr_pkg::DIST_W-1:0] b,
    input  logic [pgr_pkg::DIST_W-1:0] c,
    output logic [pgr_pkg::DIST_W-1:0] med
);
    import pgr_pkg::*;

    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;

    always_comb
    begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
            med = lo;
        else if (c >= hi)
            med = hi;
        else
            med = c;
    end

endmodule

// ----- sv/pgr_fsm.sv -----
// sample history, median and gesture state machine
// depends on pgr_pkg and pgr_median3
module pgr_fsm (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pgr_pkg::cfg_t              cfg,
    input  logic                       step_en,
    input  logic [pgr_pkg::DIST_W-1:0] in_dist,
    input  logic [pgr_pkg::TIME_W-1:0] in_time,
    output pgr_pkg::step_t             step,
    output pgr_pkg::state_t            state,
    output logic [1:0]                 count
);
    import pgr_pkg::*;

    // two stored taps; the newest sample is the third
    logic [DIST_W-1:0] hist_reg [2];
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] entry_reg;
    logic [TIME_W-1:0] entry_next;
    logic [TIME_W-1:0] lastv_reg;
    logic [TIME_W-1:0] lastv_next;

    logic [DIST_W-1:0] med_dist;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] vdt;
    logic              full;

    pgr_median3 u_median (
        .a   (in_dist),
        .b   (hist_reg[0]),
        .c   (hist_reg[1]),
        .med (med_dist)
    );

    assign dt   = in_time - entry_reg;
    assign vdt  = in_time - lastv_reg;
    assign full = (count_reg >= 2'd2);

    always_comb
    begin
        count_next = (count_reg == 2'd3) ? count_reg : count_reg + 2'd1;
        state_next = state_reg;
        entry_next = entry_reg;
        lastv_next = lastv_reg;
        step.emit  = 1'b0;
        step.code  = CODE_SWIPE;
        if (full)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (med_dist < cfg.near_distance)
                    begin
                        state_next = ST_APPROACH;
                        entry_next = in_time;
                    end
                end
                ST_APPROACH:
                begin
                    if (med_dist > cfg.far_distance)
                    begin
                        entry_next = in_time;
                        if (dt < {16'd0, cfg.swipe_max_time})
                        begin
                            state_next = ST_COOLDOWN;
                            step.emit  = 1'b1;
                            step.code  = CODE_SWIPE;
                        end
                        else if (dt < {16'd0, cfg.wave_max_time})
                            state_next = ST_RETRACT;
                        else
                            state_next = ST_IDLE;
                    end
                    else if (dt > {16'd0, cfg.hold_min_time} && med_dist < cfg.hold_distance)
                    begin
                        state_next = ST_HOLD;
                        entry_next = in_time;
                    end
                end
                ST_HOLD:
                begin
                    if (med_dist > cfg.far_distance)
                    begin
                        state_next = ST_COOLDOWN;
                        entry_next = in_time;
                        step.emit  = 1'b1;
                        step.code  = (dt > {16'd0, cfg.hold_long_time}) ? CODE_LONG_HOLD
                                                                        : CODE_SHORT_HOLD;
                    end
                end
                ST_RETRACT:
                begin
                    if (dt > DOUBLE_GAP_MS)
                    begin
                        state_next = ST_IDLE;
                        entry_next = in_time;
                    end
                    else if (med_dist < cfg.near_distance)
                    begin
                        state_next = ST_APPROACH2;
                        entry_next = in_time;
                    end
                end
                ST_APPROACH2:
                begin
                    if (med_dist > cfg.far_distance)
                    begin
                        entry_next = in_time;
                        state_next = (dt < {16'd0, cfg.wave_max_time}) ? ST_VOLUME : ST_IDLE;
                    end
                end
                ST_VOLUME:
                begin
                    if (med_dist < VOLUME_PRESENT_MM)
                    begin
                        entry_next = in_time;
                        // step limiter refreshes even outside both bands
                        if (vdt > VOLUME_STEP_MS)
                        begin
                            lastv_next = in_time;
                            if (med_dist < VOLUME_NEAR_MM)
                            begin
                                step.emit = 1'b1;
                                step.code = CODE_VOL_NEAR;
                            end
                            else if (med_dist >= VOLUME_FAR_LO_MM && med_dist < VOLUME_FAR_HI_MM)
                            begin
                                step.emit = 1'b1;
                                step.code = CODE_VOL_FAR;
                            end
                        end
                    end
                    else if (dt > VOLUME_TIMEOUT_MS)
                    begin
                        state_next = ST_COOLDOWN;
                        entry_next = in_time;
                    end
                end
                ST_COOLDOWN:
                begin
                    if (dt > {16'd0, cfg.cooldown_time})
                    begin
                        state_next = ST_IDLE;
                        entry_next = in_time;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                    entry_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            count_reg   <= '0;
            state_reg   <= ST_IDLE;
            entry_reg   <= '0;
            lastv_reg   <= '0;
        end
        else if (step_en)
        begin
            hist_reg[0] <= in_dist;
            hist_reg[1] <= hist_reg[0];
            count_reg   <= count_next;
            state_reg   <= state_next;
            entry_reg   <= entry_next;
            lastv_reg   <= lastv_next;
        end
    end

    assign state = state_reg;
    assign count = count_reg;

endmodule

// ----- sv/proximity_gesture_recognizer.sv -----
// top level of the proximity gesture recogniser
// depends on pgr_pkg, pgr_if, pgr_cfg_regs, pgr_fsm and the macros header
`include "proximity_gesture_recognizer_macros.svh"

// Takes one distance sample per clock cycle and gives zero or one gesture
// code per sample. A transfer on the sample channel lands in an input
// register; when the held sample advances, the median of the last three
// samples is formed and the gesture state machine steps in a single pass,
// and any gesture code goes into the result register. The sustained rate
// is one sample per cycle, set by that single state machine step; the
// input stage holds only while a waiting code blocks a sample that would
// produce another. The first two samples only fill the history. Register
// writes are always ready and take effect at once; write them only while
// no sample is in flight.
module proximity_gesture_recognizer (
    input  logic                 clk,
    input  logic                 rst_n,
    pgr_sample_if.sink           sample,
    pgr_gesture_if.source        gesture,
    pgr_cfg_if.sink              cfg
);
    import pgr_pkg::*;

    // input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [DIST_W-1:0] s1_dist_reg;
    logic [TIME_W-1:0] s1_time_reg;

    // result register
    logic              res_valid_reg;
    logic              res_valid_next;
    logic [CODE_W-1:0] res_code_reg;

    cfg_t              cfg_val;
    step_t             step;
    state_t            fsm_state;
    logic [1:0]        fsm_count;
    logic              advance;
    logic              take_in;

    // register writes never stall
    assign cfg.ready = 1'b1;

    pgr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    pgr_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_val),
        .step_en (advance),
        .in_dist (s1_dist_reg),
        .in_time (s1_time_reg),
        .step    (step),
        .state   (fsm_state),
        .count   (fsm_count)
    );

    // the held sample moves on unless its code would land on a waiting one
    assign advance      = s1_valid_reg && (!res_valid_reg || gesture.ready || !step.emit);
    assign sample.ready = !s1_valid_reg || advance;
    assign take_in      = sample.valid && sample.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance && step.emit)
            res_valid_next = 1'b1;
        else if (gesture.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_dist_reg <= sample.sample_distance;
            s1_time_reg <= sample.sample_time;
        end
        if (advance && step.emit)
            res_code_reg <= step.code;
    end

    assign gesture.valid        = res_valid_reg;
    assign gesture.gesture_code = res_code_reg;

    // history still filling: no gesture may come out
    `PGR_ASSERT_NOW(a_no_code_while_filling, clk, rst_n, advance && fsm_count < 2'd2, !step.emit)
    // volume codes only come from volume-slider mode
    `PGR_ASSERT_NOW(a_volume_from_volume_state, clk, rst_n, step.emit && (step.code == CODE_VOL_NEAR || step.code == CODE_VOL_FAR), fsm_state == ST_VOLUME)
    // a held sample is never overwritten
    `PGR_ASSERT_NEXT(a_input_holds, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_time_reg) && $stable(s1_dist_reg))
    // a waiting code is never dropped
    `PGR_ASSERT_NEXT(a_result_holds, clk, rst_n, res_valid_reg && !gesture.ready, res_valid_reg && $stable(res_code_reg))

endmodule

// ----- tb/proximity_gesture_recognizer_tb.sv -----
// self-checking testbench for the proximity gesture recogniser
// depends on pgr_pkg, the pgr_if interfaces and the proximity_gesture_recognizer top level
module proximity_gesture_recognizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pgr_pkg::*;

    // one sample as it goes over the sample channel
    typedef struct packed {
        logic [DIST_W-1:0] mm;
        logic [TIME_W-1:0] stamp;
    } sample_item_t;

    // distance bands that the gesture scripts aim at, taken from the live settings
    typedef enum {
        BAND_NEAR,
        BAND_HOLD,
        BAND_FAR
    } band_t;

    // register indexes past the end of the map, writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_PAST_END = 8'd8;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_TOP      = 8'hFF;

    // long enough to cover any code still in flight
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;

    pgr_sample_if  sample_ch ();
    pgr_gesture_if gesture_ch ();
    pgr_cfg_if     cfg_ch ();

    proximity_gesture_recognizer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .gesture (gesture_ch),
        .cfg     (cfg_ch)
    );

    // samples waiting for the driver, and codes the recogniser owes us
    sample_item_t  pending_samples[$];
    gesture_code_t expected_gestures[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches     = 0;
    int unsigned queued_items   = 0;

    // running timestamp of the stimulus, wraps like the sensor clock
    logic [TIME_W-1:0] t_ms = '0;

    // our own copy of the recogniser: settings, history and gesture state
    cfg_t rec_cfg = '{
        near_distance:  16'd150,
        far_distance:   16'd350,
        hold_distance:  16'd200,
        hold_min_time:  16'd800,
        hold_long_time: 16'd2000,
        swipe_max_time: 16'd300,
        wave_max_time:  16'd600,
        cooldown_time:  16'd1200
    };
    logic [DIST_W-1:0] rec_hist [3] = '{16'd0, 16'd0, 16'd0};
    logic [1:0]        rec_held      = 2'd0;
    state_t            rec_state     = ST_IDLE;
    logic [TIME_W-1:0] rec_entry     = '0;
    logic [TIME_W-1:0] rec_last_step = '0;

    // free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void enter_state(input state_t s, input logic [TIME_W-1:0] t);
        rec_state = s;
        rec_entry = t;
    endfunction

    // one step of the recogniser for an accepted sample; owed codes go on the queue
    function automatic void advance_recogniser(input logic [DIST_W-1:0] d,
                                               input logic [TIME_W-1:0] now);
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        logic [DIST_W-1:0] med;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] step_gap;

        rec_hist[2] = rec_hist[1];
        rec_hist[1] = rec_hist[0];
        rec_hist[0] = d;
        if (rec_held != 2'd3)
            rec_held = rec_held + 2'd1;
        // history still filling: nothing else moves
        if (rec_held != 2'd3)
            return;

        // median of the three held samples
        lo = (rec_hist[0] < rec_hist[1]) ? rec_hist[0] : rec_hist[1];
        hi = (rec_hist[0] < rec_hist[1]) ? rec_hist[1] : rec_hist[0];
        if (rec_hist[2] <= lo)
            med = lo;
        else if (rec_hist[2] >= hi)
            med = hi;
        else
            med = rec_hist[2];

        // elapsed time in the current state, modulo 2^32
        dt = now - rec_entry;

        case (rec_state)
            ST_IDLE:
            begin
                if (med < rec_cfg.near_distance)
                    enter_state(ST_APPROACH, now);
            end
            ST_APPROACH:
            begin
                if (med > rec_cfg.far_distance)
                begin
                    if (dt < rec_cfg.swipe_max_time)
                    begin
                        enter_state(ST_COOLDOWN, now);
                        expected_gestures.push_back(CODE_SWIPE);
                    end
                    else if (dt < rec_cfg.wave_max_time)
                        enter_state(ST_RETRACT, now);
                    else
                        enter_state(ST_IDLE, now);
                end
                else if (dt > rec_cfg.hold_min_time && med < rec_cfg.hold_distance)
                    enter_state(ST_HOLD, now);
            end
            ST_HOLD:
            begin
                if (med > rec_cfg.far_distance)
                begin
                    if (dt > rec_cfg.hold_long_time)
                        expected_gestures.push_back(CODE_LONG_HOLD);
                    else
                        expected_gestures.push_back(CODE_SHORT_HOLD);
                    enter_state(ST_COOLDOWN, now);
                end
            end
            ST_RETRACT:
            begin
                if (dt > DOUBLE_GAP_MS)
                    enter_state(ST_IDLE, now);
                else if (med < rec_cfg.near_distance)
                    enter_state(ST_APPROACH2, now);
            end
            ST_APPROACH2:
            begin
                if (med > rec_cfg.far_distance)
                begin
                    if (dt < rec_cfg.wave_max_time)
                        enter_state(ST_VOLUME, now);
                    else
                        enter_state(ST_IDLE, now);
                end
            end
            ST_VOLUME:
            begin
                if (med < VOLUME_PRESENT_MM)
                begin
                    // hand present keeps the slider alive
                    rec_entry = now;
                    step_gap  = now - rec_last_step;
                    // rate limit: the step time moves even when no band is hit
                    if (step_gap > VOLUME_STEP_MS)
                    begin
                        rec_last_step = now;
                        if (med < VOLUME_NEAR_MM)
                            expected_gestures.push_back(CODE_VOL_NEAR);
                        else if (med >= VOLUME_FAR_LO_MM && med < VOLUME_FAR_HI_MM)
                            expected_gestures.push_back(CODE_VOL_FAR);
                    end
                end
                else if (dt > VOLUME_TIMEOUT_MS)
                    enter_state(ST_COOLDOWN, now);
            end
            ST_COOLDOWN:
            begin
                if (dt > rec_cfg.cooldown_time)
                    enter_state(ST_IDLE, now);
            end
            default:
            begin
                enter_state(ST_IDLE, '0);
            end
        endcase
    endfunction

    // stimulus helpers: every sample goes through add_at so the item count stays right
    function automatic void add_at(input logic [DIST_W-1:0] d, input logic [TIME_W-1:0] stamp);
        sample_item_t s;
        s.mm    = d;
        s.stamp = stamp;
        t_ms    = stamp;
        pending_samples.push_back(s);
        queued_items++;
    endfunction

    function automatic void add_sample(input int unsigned d, input int unsigned step);
        add_at(d[DIST_W-1:0], t_ms + step);
    endfunction

    function automatic int unsigned below(input int unsigned lim);
        if (lim == 0)
            return 0;
        return $urandom_range(lim - 1, 0);
    endfunction

    function automatic int unsigned above(input int unsigned lim);
        if (lim >= 65535)
            return 65535;
        // mostly just past the threshold, now and then anywhere up to full scale
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(65535, lim + 1);
        return $urandom_range((lim + 400 > 65535) ? 65535 : lim + 400, lim + 1);
    endfunction

    function automatic int unsigned pick_distance(input band_t b);
        case (b)
            BAND_NEAR: return below(rec_cfg.near_distance);
            BAND_HOLD: return below((rec_cfg.near_distance < rec_cfg.hold_distance) ?
                                    rec_cfg.near_distance : rec_cfg.hold_distance);
            default:   return above(rec_cfg.far_distance);
        endcase
    endfunction

    // two samples in one band: the median changes on the second, lead ms after the last change
    function automatic void add_pair(input band_t b, input int unsigned lead);
        int unsigned first;
        first = $urandom_range(lead, 0);
        add_sample(pick_distance(b), first);
        add_sample(pick_distance(b), lead - first);
    endfunction

    // one random gesture attempt, timed around the live thresholds so that every branch is hit
    function automatic void queue_gesture();
        int unsigned sw;
        int unsigned wv;
        int unsigned hmin;
        int unsigned hlong;
        int unsigned n;
        int unsigned d;
        int unsigned roll;
        int unsigned step;

        sw    = rec_cfg.swipe_max_time;
        wv    = rec_cfg.wave_max_time;
        hmin  = rec_cfg.hold_min_time;
        hlong = rec_cfg.hold_long_time;
        roll  = $urandom_range(99, 0);

        if (roll < 20)
        begin
            // approach then withdraw, duration straddling the swipe limit
            add_pair(BAND_FAR, $urandom_range(200, 20));
            add_pair(BAND_NEAR, $urandom_range(60, 10));
            add_pair(BAND_FAR, $urandom_range(sw * 13 / 10 + 20, 0));
        end
        else if (roll < 40)
        begin
            // linger close for a hold, release around the long-hold limit
            add_pair(BAND_FAR, $urandom_range(200, 20));
            add_pair(BAND_HOLD, $urandom_range(60, 10));
            add_sample(pick_distance(BAND_HOLD), $urandom_range(hmin * 13 / 10 + 50, hmin * 8 / 10));
            n = $urandom_range(3, 1);
            repeat (n)
                add_sample(pick_distance(BAND_HOLD),
                           $urandom_range(hlong * 3 / (2 * n) + 30, hlong / (2 * n)));
            add_pair(BAND_FAR, $urandom_range(100, 10));
        end
        else if (roll < 75)
        begin
            // double wave into the volume slider
            add_pair(BAND_FAR, $urandom_range(200, 20));
            add_pair(BAND_NEAR, $urandom_range(60, 10));
            add_pair(BAND_FAR, $urandom_range(wv * 11 / 10 + 10, sw));
            add_pair(BAND_NEAR, $urandom_range(800, 20));
            add_pair(BAND_FAR, $urandom_range(wv * 11 / 10 + 10, 10));
            // slider dwell across all bands, steps either side of the rate limit
            n = $urandom_range(16, 4);
            repeat (n)
            begin
                case ($urandom_range(9, 0))
                    0, 1, 2: d = $urandom_range(VOLUME_NEAR_MM - 1, 0);
                    3:       d = $urandom_range(VOLUME_FAR_LO_MM - 1, VOLUME_NEAR_MM);
                    4, 5, 6: d = $urandom_range(VOLUME_FAR_HI_MM - 1, VOLUME_FAR_LO_MM);
                    7:       d = $urandom_range(VOLUME_PRESENT_MM - 1, VOLUME_FAR_HI_MM);
                    default: d = $urandom_range(65535, VOLUME_PRESENT_MM);
                endcase
                add_sample(d, $urandom_range(260, 20));
            end
            // usually walk away long enough to time the slider out
            if ($urandom_range(9, 0) < 7)
                repeat (3)
                    add_sample($urandom_range(65535, VOLUME_PRESENT_MM), $urandom_range(2500, 1500));
        end
        else
        begin
            // noise: any distance, any step, now and then a jump that wraps the clock
            n = $urandom_range(8, 3);
            repeat (n)
            begin
                step = ($urandom_range(9, 0) == 0) ? $urandom() : $urandom_range(2000, 0);
                add_sample($urandom_range(65535, 0), step);
            end
        end

        // sit out the cooldown so the next attempt usually starts from idle
        if (roll < 75)
            add_pair(BAND_FAR, rec_cfg.cooldown_time + $urandom_range(300, 1));
    endfunction

    // sample driver: presents queued samples, holds each until its transfer
    always @(posedge clk)
    begin : sample_driver
        sample_item_t next_item;
        if (rst_n)
        begin
            // transfer at this edge: the recogniser copy takes the sample
            if (sample_ch.valid && sample_ch.ready)
                advance_recogniser(sample_ch.sample_distance, sample_ch.sample_time);
            // free to present something new, or to go idle
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_item = pending_samples.pop_front();
                    sample_ch.valid           <= 1'b1;
                    sample_ch.sample_distance <= next_item.mm;
                    sample_ch.sample_time     <= next_item.stamp;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // gesture monitor: checks every transfer against the oldest owed code, stalls at random
    always @(posedge clk)
    begin : gesture_monitor
        gesture_code_t want;
        if (rst_n)
        begin
            if (gesture_ch.valid && gesture_ch.ready)
            begin
                if (expected_gestures.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: gesture_code expected none, actual %0d",
                             $time, gesture_ch.gesture_code);
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (gesture_ch.gesture_code !== want)
                    begin
                        mismatches++;
                        $display("%0t: gesture_code expected %0d, actual %0d",
                                 $time, want, gesture_ch.gesture_code);
                    end
                end
            end
            gesture_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // register write; call at a clock edge, returns after the transfer
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            CFG_NEAR_DISTANCE:  rec_cfg.near_distance  = val;
            CFG_FAR_DISTANCE:   rec_cfg.far_distance   = val;
            CFG_HOLD_DISTANCE:  rec_cfg.hold_distance  = val;
            CFG_HOLD_MIN_TIME:  rec_cfg.hold_min_time  = val;
            CFG_HOLD_LONG_TIME: rec_cfg.hold_long_time = val;
            CFG_SWIPE_MAX_TIME: rec_cfg.swipe_max_time = val;
            CFG_WAVE_MAX_TIME:  rec_cfg.wave_max_time  = val;
            CFG_COOLDOWN_TIME:  rec_cfg.cooldown_time  = val;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // block until every queued sample is through and every owed code has arrived
    task automatic wait_drained();
        while (pending_samples.size() != 0 || sample_ch.valid || expected_gestures.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int   phase;
        int   unsigned start;
        int   unsigned target;
        cfg_t c;

        // known levels on every input before the first edge
        rst_n                     = 1'b0;
        sample_ch.valid           = 1'b0;
        sample_ch.sample_distance = '0;
        sample_ch.sample_time     = '0;
        gesture_ch.ready          = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // writes outside the register map are dropped
        write_register(CFG_INDEX_PAST_END, 16'h0000);
        write_register(CFG_INDEX_TOP, 16'hFFFF);

        // directed run on the reset settings, no idling
        // first two samples only fill the history; extremes of both fields
        add_at(16'hFFFF, 32'h0000_0000);
        add_at(16'h0000, 32'hFFFF_FFFF);
        // start close to the top of the clock so the swipe timing wraps
        t_ms = 32'hFFFF_FF80;
        add_sample(500, 0);
        add_sample(500, 10);
        add_sample(100, 10);
        add_sample(100, 10);
        // quick withdraw across the wrap: swipe
        add_sample(500, 100);
        add_sample(500, 40);
        // out of cooldown, then a hold held past the long limit
        add_sample(100, 1300);
        add_sample(100, 10);
        add_sample(100, 900);
        add_sample(500, 1500);
        add_sample(500, 700);
        // out of cooldown, double wave into the slider
        add_sample(500, 1300);
        add_sample(100, 10);
        add_sample(100, 10);
        add_sample(500, 200);
        add_sample(500, 200);
        add_sample(100, 100);
        add_sample(100, 100);
        add_sample(500, 100);
        add_sample(500, 100);
        // volume near, then a far reading inside the rate limit, then volume far
        add_sample(100, 10);
        add_sample(100, 200);
        add_sample(300, 10);
        add_sample(300, 200);
        wait_drained();

        // random phases: settings and idling pattern change only while drained
        for (phase = 0; phase < 6; phase++)
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);

            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase

            case (phase)
                1:
                begin
                    // wide open: everything approaches, everything withdraws, no waiting
                    c = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                          16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000};
                end
                3:
                begin
                    // shut tight: nothing ever counts as near
                    c = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                          16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
                end
                4:
                begin
                    // back to the reset values
                    c = '{16'd150, 16'd350, 16'd200, 16'd800,
                          16'd2000, 16'd300, 16'd600, 16'd1200};
                end
                default:
                begin
                    // plausible random thresholds; the last phase uses short times
                    c.near_distance  = 16'($urandom_range(300, 80));
                    c.far_distance   = 16'(c.near_distance + $urandom_range(300, 20));
                    c.hold_distance  = 16'($urandom_range(c.near_distance + 100,
                                                          c.near_distance / 2));
                    if (phase == 5)
                    begin
                        c.hold_min_time  = 16'($urandom_range(200, 0));
                        c.hold_long_time = 16'($urandom_range(300, 0));
                        c.swipe_max_time = 16'($urandom_range(150, 0));
                        c.wave_max_time  = 16'(c.swipe_max_time + $urandom_range(200, 0));
                        c.cooldown_time  = 16'($urandom_range(200, 0));
                    end
                    else
                    begin
                        c.hold_min_time  = 16'($urandom_range(1500, 100));
                        c.hold_long_time = 16'($urandom_range(4000, 200));
                        c.swipe_max_time = 16'($urandom_range(500, 100));
                        c.wave_max_time  = 16'(c.swipe_max_time + $urandom_range(600, 50));
                        c.cooldown_time  = 16'($urandom_range(1500, 0));
                    end
                end
            endcase

            write_register(CFG_NEAR_DISTANCE, c.near_distance);
            write_register(CFG_FAR_DISTANCE, c.far_distance);
            write_register(CFG_HOLD_DISTANCE, c.hold_distance);
            write_register(CFG_HOLD_MIN_TIME, c.hold_min_time);
            write_register(CFG_HOLD_LONG_TIME, c.hold_long_time);
            write_register(CFG_SWIPE_MAX_TIME, c.swipe_max_time);
            write_register(CFG_WAVE_MAX_TIME, c.wave_max_time);
            write_register(CFG_COOLDOWN_TIME, c.cooldown_time);

            // the dead setting gets a short phase only
            target = (phase == 3) ? 120 : 300;
            start  = queued_items;
            // in some phases the sender stops halfway until every owed code is in
            if (phase == 0 || phase == 4)
            begin
                while (queued_items - start < target / 2)
                    queue_gesture();
                wait_drained();
            end
            while (queued_items - start < target)
                queue_gesture();
            wait_drained();
        end

        // quiet tail: anything arriving now is unexpected
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_gestures.size() != 0)
            $display("%0t: gesture_code expected %0d more, actual none",
                     $time, expected_gestures.size());
        if (mismatches == 0 && expected_gestures.size() == 0)
            $display("proximity_gesture_recognizer: match");
        else
            $display("proximity_gesture_recognizer: mismatch");
        $finish;
    end

    // hard stop if the handshakes hang
    initial
    begin : watchdog
        #5ms;
        $display("proximity_gesture_recognizer: mismatch");
        $finish;
    end

endmodule
